>>> rtl/rwps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwps_pkg
// shared types and constants of the roulette wheel pair select block
// ----------------------------------------------------------------------------
package rwps_pkg;

  localparam int FIT_W    = 24;
  localparam int RAND_W   = 16;
  localparam int IDX_W    = 6;
  localparam int POP_W    = 7;
  localparam int STATUS_W = 2;

  // smallest population the wheel works on
  localparam int MIN_POP = 2;

  localparam logic [POP_W-1:0] POP_RESET = 7'd64;

  // command codes
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SELECT = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_WHEEL    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FALLBACK = 2'd1;
  localparam logic [STATUS_W-1:0] ST_REJECT   = 2'd2;

  // register index, taken from the word address
  localparam logic [0:0] REG_POP_SIZE = 1'b0;

  // controller to datapath commands
  typedef struct packed {
    logic             load;       // write fitness entry
    logic             start_sel;  // clear sums, capture randoms
    logic             reject;     // equal randoms, give reject word
    logic             acc;        // read data valid in sum pass
    logic             mul;        // scale randoms by the sum
    logic             scan;       // read data valid in scan pass
    logic [IDX_W-1:0] scan_idx;   // entry under test in scan pass
    logic [IDX_W-1:0] n_low;      // effective population, low bits
    logic             finish;     // format the result word
  } dp_ctl_t;

endpackage
`default_nettype wire

>>> rtl/rwps_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwps_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module rwps_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/rwps_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwps_ctrl
// sequencer for the sum pass and the scan pass over the fitness store
// ----------------------------------------------------------------------------
module rwps_ctrl #(
  parameter int MAX_POP = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          cmd,
  input  wire logic                          rand_eq,
  input  wire logic [rwps_pkg::POP_W-1:0]    pop_size,
  output logic                               busy,
  output logic      [$clog2(MAX_POP)-1:0]    rd_addr,
  output rwps_pkg::dp_ctl_t                  ctl
);

  localparam int AW = $clog2(MAX_POP);
  localparam int CW = $clog2(MAX_POP + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_SUMW  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_SCANW = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]                 state, state_next;
  logic [CW-1:0]              cnt, cnt_next;
  logic [CW-1:0]              n, n_next;
  logic                       acc_q;
  logic                       scan_q;
  logic [rwps_pkg::IDX_W-1:0] scan_idx;
  logic                       accept;
  logic                       last;
  logic [CW-1:0]              n_eff;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign last   = (cnt == CW'(n - CW'(1)));

  // clamp the population register into the supported range
  always_comb begin
    if (32'(pop_size) < rwps_pkg::MIN_POP) begin
      n_eff = CW'(rwps_pkg::MIN_POP);
    end else if (32'(pop_size) > MAX_POP) begin
      n_eff = CW'(MAX_POP);
    end else begin
      n_eff = CW'(pop_size);
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    n_next     = n;
    case (state)
      S_IDLE: begin
        if (accept && cmd == rwps_pkg::CMD_SELECT && !rand_eq) begin
          state_next = S_SUM;
          cnt_next   = '0;
          n_next     = n_eff;
        end
      end
      S_SUM: begin
        if (last) begin
          state_next = S_SUMW;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      S_SUMW: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        state_next = S_SCAN;
        cnt_next   = '0;
      end
      S_SCAN: begin
        if (last) begin
          state_next = S_SCANW;
        end else begin
          cnt_next = cnt + CW'(1);
        end
      end
      S_SCANW: begin
        state_next = S_OUT;
      end
      S_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      n      <= CW'(MAX_POP);
      acc_q  <= 1'b0;
      scan_q <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      n      <= n_next;
      acc_q  <= (state == S_SUM);
      scan_q <= (state == S_SCAN);
    end
  end

  // index of the entry whose data arrives next cycle
  always_ff @(posedge clk) begin
    scan_idx <= rwps_pkg::IDX_W'(cnt);
  end

  assign rd_addr = cnt[AW-1:0];

  always_comb begin
    ctl           = '0;
    ctl.load      = accept && cmd == rwps_pkg::CMD_LOAD;
    ctl.start_sel = accept && cmd == rwps_pkg::CMD_SELECT && !rand_eq;
    ctl.reject    = accept && cmd == rwps_pkg::CMD_SELECT && rand_eq;
    ctl.acc       = acc_q;
    ctl.mul       = (state == S_MUL);
    ctl.scan      = scan_q;
    ctl.scan_idx  = scan_idx;
    ctl.n_low     = rwps_pkg::IDX_W'(n);
    ctl.finish    = (state == S_OUT);
  end

  a_cnt_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SUM || state == S_SCAN) |-> (cnt < n))
    else $error("address counter ran past population");

endmodule
`default_nettype wire

>>> rtl/rwps_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rwps_dp
// fitness store, sum accumulator, scaled randoms and pick registers
// ----------------------------------------------------------------------------
module rwps_dp #(
  parameter int MAX_POP = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rwps_pkg::dp_ctl_t                ctl,
  input  wire logic [$clog2(MAX_POP)-1:0]       rd_addr,
  input  wire logic [rwps_pkg::IDX_W-1:0]       index,
  input  wire logic [rwps_pkg::FIT_W-1:0]       fitness,
  input  wire logic [rwps_pkg::RAND_W-1:0]      rand_a,
  input  wire logic [rwps_pkg::RAND_W-1:0]      rand_b,
  output logic                                  rand_eq,
  output logic                                  done,
  output logic      [rwps_pkg::IDX_W-1:0]       first_parent,
  output logic      [rwps_pkg::IDX_W-1:0]       second_parent,
  output logic      [rwps_pkg::STATUS_W-1:0]    status
);

  localparam int AW = $clog2(MAX_POP);
  localparam int SW = rwps_pkg::FIT_W + $clog2(MAX_POP);
  localparam int PW = SW + rwps_pkg::RAND_W;

  logic [rwps_pkg::FIT_W-1:0]  rd_data;
  logic                        we;
  logic [rwps_pkg::RAND_W-1:0] ra, rb;
  logic [SW-1:0]               sum;
  logic [SW-1:0]               cum;
  logic [SW-1:0]               cum_hi;
  logic [PW-1:0]               sa, sb;
  logic [PW-1:0]               lo_s, hi_s;
  logic                        a_hit, b_hit;
  logic [1:0]                  count;
  logic [rwps_pkg::IDX_W-1:0]  pick0, pick1;

  assign rand_eq = (rand_a == rand_b);
  assign we      = ctl.load && (32'(index) < MAX_POP);

  rwps_ram #(
    .WIDTH (rwps_pkg::FIT_W),
    .DEPTH (MAX_POP)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (AW'(index)),
    .wdata (fitness),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // interval test: r*S strictly between cum<<16 and (cum+f)<<16
  assign cum_hi = cum + SW'(rd_data);
  assign lo_s   = {cum, {rwps_pkg::RAND_W{1'b0}}};
  assign hi_s   = {cum_hi, {rwps_pkg::RAND_W{1'b0}}};
  assign a_hit  = (sa > lo_s) && (sa < hi_s);
  assign b_hit  = (sb > lo_s) && (sb < hi_s);

  always_ff @(posedge clk) begin
    if (ctl.start_sel) begin
      ra  <= rand_a;
      rb  <= rand_b;
      sum <= '0;
      cum <= '0;
    end else begin
      if (ctl.acc) begin
        sum <= sum + SW'(rd_data);
      end
      if (ctl.scan) begin
        cum <= cum_hi;
      end
    end
    if (ctl.mul) begin
      sa <= PW'(ra) * PW'(sum);
      sb <= PW'(rb) * PW'(sum);
    end
  end

  // picks in push order, rand_a before rand_b within one entry
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (ctl.start_sel) begin
      count <= 2'd0;
    end else if (ctl.scan) begin
      case (count)
        2'd0: begin
          if (a_hit && b_hit) begin
            count <= 2'd2;
          end else if (a_hit || b_hit) begin
            count <= 2'd1;
          end
        end
        2'd1: begin
          if (a_hit || b_hit) begin
            count <= 2'd2;
          end
        end
        default: begin
          count <= count;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      if (count == 2'd0 && (a_hit || b_hit)) begin
        pick0 <= ctl.scan_idx;
      end
      if ((count == 2'd0 && a_hit && b_hit) || (count == 2'd1 && (a_hit || b_hit))) begin
        pick1 <= ctl.scan_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.finish || ctl.reject;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.reject) begin
      first_parent  <= '0;
      second_parent <= '0;
      status        <= rwps_pkg::ST_REJECT;
    end else if (ctl.finish) begin
      status        <= (count == 2'd2) ? rwps_pkg::ST_WHEEL : rwps_pkg::ST_FALLBACK;
      first_parent  <= (count == 2'd0) ? ctl.n_low - rwps_pkg::IDX_W'(rwps_pkg::MIN_POP)
                                       : pick0;
      second_parent <= (count == 2'd2) ? pick1 : ctl.n_low - rwps_pkg::IDX_W'(1);
    end
  end

endmodule
`default_nettype wire

>>> rtl/roulette_wheel_pair_select.sv
`default_nettype none
// ----------------------------------------------------------------------------
// roulette_wheel_pair_select
// fitness-proportional selection of two parents from a stored population
// ----------------------------------------------------------------------------
// load word: accepted while idle, no result, busy stays low
// select word: busy for a sum pass and a scan pass over N entries (N = clamped
//   pop_size), done strobe in the cycle after busy ends; both passes go through
//   the single read port of the fitness store, one entry per cycle in each
//   pass, and no new word is taken while busy
// select with equal randoms: reject result in the cycle after accept, no busy time
// reset: controller idle, pop_size back to 64; the fitness store is not cleared
// results are shown for exactly one cycle, the receiver cannot stall
module roulette_wheel_pair_select #(
  parameter int MAX_POP = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // command side
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cmd,
  input  wire logic [rwps_pkg::IDX_W-1:0]        index,
  input  wire logic [rwps_pkg::FIT_W-1:0]        fitness,
  input  wire logic [rwps_pkg::RAND_W-1:0]       rand_a,
  input  wire logic [rwps_pkg::RAND_W-1:0]       rand_b,
  // result side
  output logic                                   done,
  output logic      [rwps_pkg::IDX_W-1:0]        first_parent,
  output logic      [rwps_pkg::IDX_W-1:0]        second_parent,
  output logic      [rwps_pkg::STATUS_W-1:0]     status,
  // register port
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [2:0]                        paddr,
  input  wire logic [31:0]                       pwdata,
  output logic      [31:0]                       prdata,
  output logic                                   pready
);

  localparam int AW = $clog2(MAX_POP);

  logic [rwps_pkg::POP_W-1:0] pop_size;
  logic                       reg_wr;
  logic                       rand_eq;
  logic [AW-1:0]              rd_addr;
  rwps_pkg::dp_ctl_t          ctl;

  // register file: pop_size only, word address in paddr[2]
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pop_size <= rwps_pkg::POP_RESET;
    end else if (reg_wr && paddr[2:2] == rwps_pkg::REG_POP_SIZE) begin
      pop_size <= pwdata[rwps_pkg::POP_W-1:0];
    end
  end

  assign prdata = (paddr[2:2] == rwps_pkg::REG_POP_SIZE) ? 32'(pop_size) : 32'd0;

  // sequencer: walks the store twice, first to sum then to scan intervals
  rwps_ctrl #(
    .MAX_POP (MAX_POP)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .cmd      (cmd),
    .rand_eq  (rand_eq),
    .pop_size (pop_size),
    .busy     (busy),
    .rd_addr  (rd_addr),
    .ctl      (ctl)
  );

  // datapath: store, accumulator, scaled randoms, picks and result word
  rwps_dp #(
    .MAX_POP (MAX_POP)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .rd_addr       (rd_addr),
    .index         (index),
    .fitness       (fitness),
    .rand_a        (rand_a),
    .rand_b        (rand_b),
    .rand_eq       (rand_eq),
    .done          (done),
    .first_parent  (first_parent),
    .second_parent (second_parent),
    .status        (status)
  );

  // a result word only appears once the sequencer is back in idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result word while busy");

  // a rejected select carries zero parents
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status == rwps_pkg::ST_REJECT) |-> (first_parent == '0 && second_parent == '0))
    else $error("reject word with nonzero parents");

  // only an accepted select starts the passes
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start && cmd == rwps_pkg::CMD_SELECT))
    else $error("busy without a select word");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == rwps_pkg::ST_WHEEL || status == rwps_pkg::ST_FALLBACK ||
              status == rwps_pkg::ST_REJECT))
    else $error("undefined status code");

endmodule
`default_nettype wire

>>> verif/roulette_wheel_pair_select_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// roulette_wheel_pair_select_tb
// self-checking bench for the roulette wheel pair select block
// ----------------------------------------------------------------------------
// a behavioral copy of the wheel (fitness store, pop_size, sum and scan)
// predicts each result word when a select word is accepted; the result side
// pops predictions in order and compares every field. fitness loads and
// selects go in through the command port under three sender idle profiles,
// and pop_size is swept through the register port while the block is idle.
// ----------------------------------------------------------------------------
module roulette_wheel_pair_select_tb;

  localparam int POP_MAX     = 64;
  // no handshake for this many cycles means the block is stuck
  localparam int STALL_LIMIT = 2000;
  // a load has no result; give it time to land before touching pop_size
  localparam int SETTLE_CYC  = 4;
  // one full select at the largest population, plus margin
  localparam int TAIL_CYC    = 2 * POP_MAX + 8;
  localparam int MAX_GAP     = 40;
  localparam int PHASE_WORDS = 550;

  typedef struct packed {
    logic [rwps_pkg::IDX_W-1:0]    first_parent;
    logic [rwps_pkg::IDX_W-1:0]    second_parent;
    logic [rwps_pkg::STATUS_W-1:0] status;
  } pair_word_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // command side, all known from time zero
  logic                          start   = 1'b0;
  logic                          cmd     = rwps_pkg::CMD_LOAD;
  logic [rwps_pkg::IDX_W-1:0]    index   = '0;
  logic [rwps_pkg::FIT_W-1:0]    fitness = '0;
  logic [rwps_pkg::RAND_W-1:0]   rand_a  = '0;
  logic [rwps_pkg::RAND_W-1:0]   rand_b  = '0;
  logic                          busy;

  // result side
  logic                          done;
  logic [rwps_pkg::IDX_W-1:0]    first_parent;
  logic [rwps_pkg::IDX_W-1:0]    second_parent;
  logic [rwps_pkg::STATUS_W-1:0] status;

  // register port
  logic                          psel    = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite  = 1'b0;
  logic [2:0]                    paddr   = '0;
  logic [31:0]                   pwdata  = '0;
  logic [31:0]                   prdata;
  logic                          pready;

  // bench copy of the block state
  logic [rwps_pkg::FIT_W-1:0]    fit_mirror [POP_MAX];
  logic [rwps_pkg::POP_W-1:0]    pop_mirror = rwps_pkg::POP_RESET;

  // predicted result words, oldest first
  pair_word_t          parents_due [$];
  pair_word_t          head_word;

  int                  err_cnt    = 0;
  int                  stall_cnt  = 0;
  int                  idle_pct   = 0;
  int                  burst_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  roulette_wheel_pair_select #(.MAX_POP(POP_MAX)) DUT (.*);

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // pop_size as the block uses it: clamped to the legal population range
  function automatic int unsigned effective_pop();
    if (pop_mirror < rwps_pkg::MIN_POP) return rwps_pkg::MIN_POP;
    if (pop_mirror > POP_MAX) return POP_MAX;
    return pop_mirror;
  endfunction

  // wheel selection on the mirrored store; the interval test is done on
  // exact products, r*S against cum<<16, so no rounding can creep in
  function automatic pair_word_t predict_parents(logic [rwps_pkg::RAND_W-1:0] ra,
                                                 logic [rwps_pkg::RAND_W-1:0] rb);
    int unsigned                n;
    int unsigned                picked;
    logic [rwps_pkg::IDX_W-1:0] pick [2];
    logic [63:0]                total;
    logic [63:0]                run;
    logic [63:0]                sa;
    logic [63:0]                sb;
    logic [63:0]                lo;
    logic [63:0]                hi;
    pair_word_t                 w;
    w = '0;
    // equal randoms are turned away before any wheel work
    if (ra == rb) begin
      w.status = rwps_pkg::ST_REJECT;
      return w;
    end
    n = effective_pop();
    total = '0;
    run = '0;
    picked = 0;
    pick[0] = '0;
    pick[1] = '0;
    for (int i = 0; i < n; i++) total += 64'(fit_mirror[i]);
    sa = 64'(ra) * total;
    sb = 64'(rb) * total;
    // entries in index order, rand_a tested before rand_b on each entry
    for (int i = 0; i < n; i++) begin
      lo = run << 16;
      hi = (run + 64'(fit_mirror[i])) << 16;
      if (sa > lo && sa < hi && picked < 2) begin
        pick[picked] = rwps_pkg::IDX_W'(i);
        picked++;
      end
      if (sb > lo && sb < hi && picked < 2) begin
        pick[picked] = rwps_pkg::IDX_W'(i);
        picked++;
      end
      run += 64'(fit_mirror[i]);
    end
    // missing picks come from the top of the population
    w.status = (picked < 2) ? rwps_pkg::ST_FALLBACK : rwps_pkg::ST_WHEEL;
    while (picked < 2) begin
      pick[picked] = rwps_pkg::IDX_W'(n - (2 - picked));
      picked++;
    end
    w.first_parent  = pick[0];
    w.second_parent = pick[1];
    return w;
  endfunction

  // ------------------------------------------------------------------------
  // result checking, one word per done strobe
  // ------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done) begin
      if (parents_due.size() == 0) begin
        $error("result word with no select pending: %0d %0d %0d",
               first_parent, second_parent, status);
        err_cnt++;
      end else begin
        head_word = parents_due.pop_front();
        if (first_parent !== head_word.first_parent) begin
          $error("first_parent: expected %0d, actual %0d",
                 head_word.first_parent, first_parent);
          err_cnt++;
        end
        if (second_parent !== head_word.second_parent) begin
          $error("second_parent: expected %0d, actual %0d",
                 head_word.second_parent, second_parent);
          err_cnt++;
        end
        if (status !== head_word.status) begin
          $error("status: expected %0d, actual %0d", head_word.status, status);
          err_cnt++;
        end
      end
    end
  end

  // watchdog: any accepted command word or result word clears it
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt == STALL_LIMIT) begin
      $display("roulette_wheel_pair_select_tb: done, errors");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // drivers
  // ------------------------------------------------------------------------

  // present one command word and hold it until the block takes it; start
  // stays high on return so back-to-back words need no low cycle
  task automatic send_word(logic c, logic [rwps_pkg::IDX_W-1:0] idx,
                           logic [rwps_pkg::FIT_W-1:0] fit,
                           logic [rwps_pkg::RAND_W-1:0] ra,
                           logic [rwps_pkg::RAND_W-1:0] rb);
    start   <= 1'b1;
    cmd     <= c;
    index   <= idx;
    fitness <= fit;
    rand_a  <= ra;
    rand_b  <= rb;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    if (c == rwps_pkg::CMD_LOAD) begin
      fit_mirror[idx] = fit;
    end else begin
      parents_due.insert(parents_due.size(), predict_parents(ra, rb));
    end
  endtask

  task automatic load_entry(logic [rwps_pkg::IDX_W-1:0] idx,
                            logic [rwps_pkg::FIT_W-1:0] fit);
    send_word(rwps_pkg::CMD_LOAD, idx, fit, '0, '0);
  endtask

  task automatic select_pair(logic [rwps_pkg::RAND_W-1:0] ra,
                             logic [rwps_pkg::RAND_W-1:0] rb);
    send_word(rwps_pkg::CMD_SELECT, '0, '0, ra, rb);
  endtask

  // sender idling between words, with occasional bursts of no idling
  task automatic sender_gap();
    int n;
    n = 0;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    if ($urandom_range(0, 99) < 6) begin
      burst_left = 16;
      return;
    end
    while (n < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      n++;
    end
  endtask

  // hold off until every predicted word has come back and the last load
  // has had time to settle
  task automatic wait_idle();
    start <= 1'b0;
    while (parents_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // setup then access cycle; the register takes the value when pready is high
  task automatic write_pop(logic [rwps_pkg::POP_W-1:0] val);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {rwps_pkg::REG_POP_SIZE, 2'b00};
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    pop_mirror = val;
  endtask

  // pop_size mostly small to keep selects short, with the clamped extremes
  function automatic logic [rwps_pkg::POP_W-1:0] random_pop();
    case ($urandom_range(0, 9))
      0: return rwps_pkg::POP_W'($urandom_range(0, 1));
      1: return rwps_pkg::POP_W'(POP_MAX);
      2: return rwps_pkg::POP_W'($urandom_range(POP_MAX + 1, 127));
      3: return rwps_pkg::POP_W'($urandom_range(rwps_pkg::MIN_POP, POP_MAX));
      default: return rwps_pkg::POP_W'($urandom_range(rwps_pkg::MIN_POP, 12));
    endcase
  endfunction

  // one random command word: loads land mostly inside the active population;
  // fitness and randoms are skewed toward zero, powers of two and aligned
  // values so that interval edges and zero sums come up often
  task automatic random_word();
    int unsigned                 n;
    logic [rwps_pkg::FIT_W-1:0]  fit;
    logic [rwps_pkg::RAND_W-1:0] ra;
    logic [rwps_pkg::RAND_W-1:0] rb;
    logic [rwps_pkg::IDX_W-1:0]  idx;
    n = effective_pop();
    fit = rwps_pkg::FIT_W'($urandom);
    case ($urandom_range(0, 5))
      0: fit = '0;
      1: fit = rwps_pkg::FIT_W'($urandom_range(0, 255));
      2: fit = rwps_pkg::FIT_W'(1) << $urandom_range(0, rwps_pkg::FIT_W - 1);
      3: fit = '1;
      default: ;
    endcase
    ra = rwps_pkg::RAND_W'($urandom);
    rb = rwps_pkg::RAND_W'($urandom);
    case ($urandom_range(0, 9))
      0: rb = ra;
      1: ra = '0;
      2: rb = '1;
      3: begin
        ra = rwps_pkg::RAND_W'($urandom_range(0, 15)) << 12;
        rb = rwps_pkg::RAND_W'($urandom_range(0, 15)) << 12;
      end
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) begin
      idx = rwps_pkg::IDX_W'($urandom_range(0, POP_MAX - 1));
    end else begin
      idx = rwps_pkg::IDX_W'($urandom_range(0, n - 1));
    end
    if ($urandom_range(0, 99) < 45) begin
      send_word(rwps_pkg::CMD_LOAD, idx, fit, ra, rb);
    end else begin
      send_word(rwps_pkg::CMD_SELECT, idx, fit, ra, rb);
    end
    sender_gap();
  endtask

  // ------------------------------------------------------------------------
  // tests
  // ------------------------------------------------------------------------

  // every entry written once, so no select can ever read an unwritten one
  task automatic test_fill_store();
    for (int i = 0; i < POP_MAX; i++) begin
      load_entry(rwps_pkg::IDX_W'(i), rwps_pkg::FIT_W'($urandom));
    end
  endtask

  // selects before any register write run on the reset pop_size
  task automatic test_reset_pop_size();
    repeat (3) select_pair(rwps_pkg::RAND_W'($urandom), rwps_pkg::RAND_W'($urandom));
  endtask

  task automatic test_wheel_edges();
    write_pop(rwps_pkg::POP_W'(2));
    load_entry(6'd0, rwps_pkg::FIT_W'(32768));
    load_entry(6'd1, rwps_pkg::FIT_W'(32768));
    // rand_a exactly on the boundary between the two entries picks nothing
    select_pair(16'd32768, 16'd16384);
    // zero never lies strictly inside, the top value lands in the last entry
    select_pair(16'd0, 16'hFFFF);
    // equal randoms
    select_pair(16'd12345, 16'd12345);
    // both randoms in the same entry
    select_pair(16'd100, 16'd200);
    // zero sum, fallback to the top two
    load_entry(6'd0, '0);
    load_entry(6'd1, '0);
    select_pair(16'd1, 16'd2);
    // largest fitness; rand_b hits entry 0 first, so it is pushed first
    load_entry(6'd0, '1);
    load_entry(6'd1, '1);
    select_pair(16'hFFFF, 16'h0001);
    // pop_size below the minimum acts as the minimum
    write_pop(rwps_pkg::POP_W'(0));
    select_pair(16'd40000, 16'd30000);
    write_pop(rwps_pkg::POP_W'(1));
    select_pair(16'd1, 16'd65534);
    // zero-fitness entries are skipped, both picks on the last entry
    write_pop(rwps_pkg::POP_W'(3));
    load_entry(6'd0, '0);
    load_entry(6'd1, '0);
    load_entry(6'd2, rwps_pkg::FIT_W'(5));
    select_pair(16'd1, 16'hFFFF);
    // pop_size above the store acts as the full store
    write_pop(rwps_pkg::POP_W'(127));
    select_pair(16'hFFFF, 16'h0000);
    write_pop(rwps_pkg::POP_W'(65));
    select_pair(16'h8000, 16'h7FFF);
    write_pop(rwps_pkg::POP_W'(POP_MAX));
    select_pair(16'h0000, 16'h0000);
  endtask

  // random traffic at one sender idle rate, pop_size changed every few dozen
  task automatic test_random_traffic(int pct);
    int sent;
    sent = 0;
    idle_pct = pct;
    burst_left = 0;
    while (sent < PHASE_WORDS) begin
      write_pop(random_pop());
      repeat ($urandom_range(30, 80)) begin
        random_word();
        sent++;
      end
    end
  endtask

  // sender stops until the result side has caught up, then resumes
  task automatic test_drain_pause();
    idle_pct = 0;
    repeat (20) random_word();
    wait_idle();
    repeat (20) random_word();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_fill_store();
    test_reset_pop_size();
    test_wheel_edges();
    test_random_traffic(38);
    test_random_traffic(86);
    test_drain_pause();
    test_random_traffic(0);
    // all words sent: wait out the last results, then watch for strays
    wait_idle();
    repeat (TAIL_CYC) @(posedge clk);
    if (err_cnt == 0) begin
      $display("roulette_wheel_pair_select_tb: done, clean");
    end else begin
      $display("roulette_wheel_pair_select_tb: done, errors");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rwps_pkg.sv
rtl/rwps_ram.sv
rtl/rwps_ctrl.sv
rtl/rwps_dp.sv
rtl/roulette_wheel_pair_select.sv
verif/roulette_wheel_pair_select_tb.sv
